### design/gtnl_pkg.sv
`timescale 1ns / 1ps

package gtnl_pkg;

    localparam int TREE_DEPTH_DEF = 10;
    localparam int COORD_BITS_DEF = 32;

    localparam int IDX_W       = 11;
    localparam int DEPTH_OUT_W = 4;

    localparam int AXIS_PATTERN_LEN = 21;

    localparam logic [1:0] AXIS_X = 2'd0;
    localparam logic [1:0] AXIS_Y = 2'd1;
    localparam logic [1:0] AXIS_Z = 2'd2;

    localparam logic [1:0] AXIS_PATTERN [0:AXIS_PATTERN_LEN-1] = '{
        AXIS_X, AXIS_Y, AXIS_X, AXIS_Y, AXIS_X, AXIS_Y, AXIS_Z,
        AXIS_X, AXIS_Y, AXIS_X, AXIS_Y, AXIS_X, AXIS_Y, AXIS_Z,
        AXIS_X, AXIS_Y, AXIS_X, AXIS_Y, AXIS_X, AXIS_Y, AXIS_Z
    };

    localparam logic MODE_WRITE = 1'b0;
    localparam logic MODE_QUERY = 1'b1;

    typedef struct packed {
        logic start_write;
        logic start_query;
        logic step;
        logic load_out;
    } t_dp_cmd;

    typedef struct packed {
        logic walk_done;
        logic out_free;
    } t_dp_status;

    function automatic logic [1:0] axis_of_depth(input logic [4:0] d);
        logic [1:0] a;
        a = AXIS_X;
        if (d < 5'(AXIS_PATTERN_LEN)) begin
            a = AXIS_PATTERN[d];
        end
        return a;
    endfunction

endpackage

### design/gtnl_ctrl.sv
`timescale 1ns / 1ps

module gtnl_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                i_mode,
    input  gtnl_pkg::t_dp_status i_status,
    output logic                o_in_ready,
    output gtnl_pkg::t_dp_cmd   o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_WALK,
        S_HOLD
    } t_state;

    t_state r_state;
    t_state n_state;

    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    if (i_mode == gtnl_pkg::MODE_WRITE) begin
                        o_cmd.start_write = 1'b1;
                        if (i_status.out_free) begin
                            o_cmd.load_out = 1'b1;
                        end else begin
                            n_state = S_HOLD;
                        end
                    end else begin
                        o_cmd.start_query = 1'b1;
                        n_state           = S_WALK;
                    end
                end
            end
            S_WALK: begin
                o_cmd.step = 1'b1;
                if (i_status.walk_done) begin
                    if (i_status.out_free) begin
                        o_cmd.load_out = 1'b1;
                        n_state        = S_IDLE;
                    end else begin
                        n_state = S_HOLD;
                    end
                end
            end
            S_HOLD: begin
                if (i_status.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    a_one_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({o_cmd.start_write, o_cmd.start_query, o_cmd.step}))
        else $error("conflicting datapath commands");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load_out |-> i_status.out_free)
        else $error("result loaded over a pending one");

    a_query_walks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.start_query |=> (r_state == S_WALK))
        else $error("query did not start walking");

endmodule

### design/gtnl_datapath.sv
`timescale 1ns / 1ps

module gtnl_datapath #(
    parameter int TREE_DEPTH = gtnl_pkg::TREE_DEPTH_DEF,
    parameter int COORD_BITS = gtnl_pkg::COORD_BITS_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  gtnl_pkg::t_dp_cmd                    i_cmd,
    output gtnl_pkg::t_dp_status                 o_status,
    input  logic [gtnl_pkg::IDX_W-1:0]           i_node_index,
    input  logic signed [COORD_BITS-1:0]         i_node_low,
    input  logic signed [COORD_BITS-1:0]         i_node_high,
    input  logic signed [COORD_BITS-1:0]         i_box_min_x,
    input  logic signed [COORD_BITS-1:0]         i_box_min_y,
    input  logic signed [COORD_BITS-1:0]         i_box_min_z,
    input  logic signed [COORD_BITS-1:0]         i_box_max_x,
    input  logic signed [COORD_BITS-1:0]         i_box_max_y,
    input  logic signed [COORD_BITS-1:0]         i_box_max_z,
    input  logic                                 i_out_ready,
    output logic                                 o_out_valid,
    output logic [gtnl_pkg::IDX_W-1:0]           o_found_node,
    output logic [gtnl_pkg::DEPTH_OUT_W-1:0]     o_found_depth,
    output logic                                 o_straddles
);

    localparam int IW         = gtnl_pkg::IDX_W;
    localparam int AW         = TREE_DEPTH + 1;
    localparam int NODE_COUNT = (2 ** AW) - 1;
    localparam int DW         = $clog2(TREE_DEPTH + 1);
    localparam int WW         = (IW > AW) ? IW : AW;

    logic [2*COORD_BITS-1:0] mem [0:NODE_COUNT-1];
    logic [2*COORD_BITS-1:0] r_rdata;

    logic signed [COORD_BITS-1:0] r_min_x, r_min_y, r_min_z;
    logic signed [COORD_BITS-1:0] r_max_x, r_max_y, r_max_z;

    logic [AW-1:0] r_node,     n_node;
    logic [DW-1:0] r_depth,    n_depth;
    logic          r_straddle, n_straddle;
    logic [IW-1:0] r_res_node, n_res_node;
    logic          r_out_valid;

    logic signed [COORD_BITS-1:0] lo, hi, bmin, bmax;
    logic [1:0]    axis;
    logic [AW-1:0] node_x2;
    logic [AW-1:0] child;
    logic [DW-1:0] depth_inc;
    logic          go_high, stop_here;
    logic          idx_ok;
    logic [AW-1:0] wr_addr, rd_addr;

    assign lo        = $signed(r_rdata[COORD_BITS-1:0]);
    assign hi        = $signed(r_rdata[2*COORD_BITS-1:COORD_BITS]);
    assign axis      = gtnl_pkg::axis_of_depth(5'(r_depth));
    assign node_x2   = {r_node[AW-2:0], 1'b0};
    assign depth_inc = r_depth + DW'(1);
    assign idx_ok    = (WW'(i_node_index) < WW'(NODE_COUNT));
    assign wr_addr   = AW'(i_node_index);

    always_comb begin
        case (axis)
            gtnl_pkg::AXIS_Y: begin
                bmin = r_min_y;
                bmax = r_max_y;
            end
            gtnl_pkg::AXIS_Z: begin
                bmin = r_min_z;
                bmax = r_max_z;
            end
            default: begin
                bmin = r_min_x;
                bmax = r_max_x;
            end
        endcase
    end

    assign go_high   = (hi >= bmax);
    assign stop_here = !go_high && (lo > bmin);
    assign child     = node_x2 + (go_high ? AW'(2) : AW'(1));

    always_comb begin
        n_node     = r_node;
        n_depth    = r_depth;
        n_straddle = r_straddle;
        n_res_node = r_res_node;
        if (i_cmd.start_write) begin
            n_node     = '0;
            n_depth    = '0;
            n_straddle = 1'b0;
            n_res_node = i_node_index;
        end else if (i_cmd.start_query) begin
            n_node     = '0;
            n_depth    = '0;
            n_straddle = 1'b0;
            n_res_node = '0;
        end else if (i_cmd.step) begin
            if (stop_here) begin
                n_straddle = 1'b1;
            end else begin
                n_node     = child;
                n_depth    = depth_inc;
                n_res_node = IW'(child);
            end
        end
    end

    assign rd_addr = i_cmd.start_query ? '0 : n_node;

    assign o_status.walk_done = stop_here || (depth_inc == DW'(TREE_DEPTH));
    assign o_status.out_free  = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (i_cmd.start_write && idx_ok) begin
            mem[wr_addr] <= {i_node_high, i_node_low};
        end
        r_rdata <= mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start_query) begin
            r_min_x <= i_box_min_x;
            r_min_y <= i_box_min_y;
            r_min_z <= i_box_min_z;
            r_max_x <= i_box_max_x;
            r_max_y <= i_box_max_y;
            r_max_z <= i_box_max_z;
        end
        r_node     <= n_node;
        r_depth    <= n_depth;
        r_straddle <= n_straddle;
        r_res_node <= n_res_node;
        if (i_cmd.load_out) begin
            o_found_node  <= n_res_node;
            o_found_depth <= gtnl_pkg::DEPTH_OUT_W'(n_depth);
            o_straddles   <= n_straddle;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out_valid = r_out_valid;

    a_step_depth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.step |-> (r_depth < DW'(TREE_DEPTH)))
        else $error("walk stepped past the last level");

    a_query_root: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.start_query |=> (r_node == '0) && (r_depth == '0) && !r_straddle)
        else $error("query did not start at the root");

    a_straddle_depth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.load_out && n_straddle) |-> (n_depth < DW'(TREE_DEPTH)))
        else $error("straddle reported at full depth");

endmodule

### design/grid_tree_node_lookup_unit.sv
`timescale 1ns / 1ps

// Grid tree node lookup.
// Input channel (i_in_valid / o_in_ready) carries one request: mode 0 stores
// a node's low/high split bounds at node_index, mode 1 walks the tree with
// the query box. Output channel (o_out_valid / i_out_ready) returns one
// result per request: the node and depth where the walk ended and a
// straddle flag, or the echoed index for a write.
// A write's result is loaded into the output register as it is accepted,
// or once the output register frees up. A query reads and compares one
// node per tree level; the root read happens in the accept cycle, and the
// walk ends early when the box straddles a node's split. The next request
// is taken once the query's result has been loaded into the output register.
// One request is in flight at a time; o_in_ready is high while idle.
// A finished result sits in the output register until taken; if the
// receiver stalls while another result is done, the unit waits and does not
// accept the next request until the output register frees up.
// Reset clears control state and output valid. The node table is not
// cleared; nodes must be written before a query reads them.

module grid_tree_node_lookup_unit #(
    parameter int TREE_DEPTH = gtnl_pkg::TREE_DEPTH_DEF,
    parameter int COORD_BITS = gtnl_pkg::COORD_BITS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  logic                             i_mode,
    input  logic [gtnl_pkg::IDX_W-1:0]       i_node_index,
    input  logic signed [COORD_BITS-1:0]     i_node_low,
    input  logic signed [COORD_BITS-1:0]     i_node_high,
    input  logic signed [COORD_BITS-1:0]     i_box_min_x,
    input  logic signed [COORD_BITS-1:0]     i_box_min_y,
    input  logic signed [COORD_BITS-1:0]     i_box_min_z,
    input  logic signed [COORD_BITS-1:0]     i_box_max_x,
    input  logic signed [COORD_BITS-1:0]     i_box_max_y,
    input  logic signed [COORD_BITS-1:0]     i_box_max_z,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output logic [gtnl_pkg::IDX_W-1:0]       o_found_node,
    output logic [gtnl_pkg::DEPTH_OUT_W-1:0] o_found_depth,
    output logic                             o_straddles
);

    gtnl_pkg::t_dp_cmd    cmd;
    gtnl_pkg::t_dp_status status;

    gtnl_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_mode     (i_mode),
        .i_status   (status),
        .o_in_ready (o_in_ready),
        .o_cmd      (cmd)
    );

    gtnl_datapath #(
        .TREE_DEPTH (TREE_DEPTH),
        .COORD_BITS (COORD_BITS)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_status      (status),
        .i_node_index  (i_node_index),
        .i_node_low    (i_node_low),
        .i_node_high   (i_node_high),
        .i_box_min_x   (i_box_min_x),
        .i_box_min_y   (i_box_min_y),
        .i_box_min_z   (i_box_min_z),
        .i_box_max_x   (i_box_max_x),
        .i_box_max_y   (i_box_max_y),
        .i_box_max_z   (i_box_max_z),
        .i_out_ready   (i_out_ready),
        .o_out_valid   (o_out_valid),
        .o_found_node  (o_found_node),
        .o_found_depth (o_found_depth),
        .o_straddles   (o_straddles)
    );

endmodule
